@@ hw/rtl/rfc_pkg.sv @@
// shared types, constants and the crc byte update for the relay frame checker
package rfc_pkg;

    // frame layout
    localparam int unsigned HEADER_BYTES = 9;
    localparam int unsigned CRC_BYTES    = 2;

    // byte position counter, saturating
    localparam int unsigned  POS_W   = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // crc16 ccitt constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FIRST_VALID   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_END_EXCLUSIVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_BAD_TYPE  = 2'd2,
        ST_CRC_ERR   = 2'd3
    } t_status;

    // configuration register set
    typedef struct packed {
        logic [7:0] type_first_valid;
        logic [8:0] type_end_exclusive;
    } t_cfg;

    // one result item
    typedef struct packed {
        t_status     status;
        logic [7:0]  msg_kind;
        logic [7:0]  hops_taken;
        logic [7:0]  hops_allowed;
        logic [31:0] origin_node;
        logic [15:0] body_length;
    } t_result;

    // crc16 ccitt update with one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/rfc_if.sv @@
// byte input and result output channel interfaces

interface rfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface rfc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  msg_kind;
    logic [7:0]  hops_taken;
    logic [7:0]  hops_allowed;
    logic [31:0] origin_node;
    logic [15:0] body_length;

    modport source (output valid, output status, output msg_kind, output hops_taken,
                    output hops_allowed, output origin_node, output body_length,
                    input ready);
    modport sink   (input valid, input status, input msg_kind, input hops_taken,
                    input hops_allowed, input origin_node, input body_length,
                    output ready);
endinterface

@@ hw/rtl/rfc_cfg_regs.sv @@
// configuration registers for the accepted message type window
module rfc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rfc_pkg::t_cfg                  o_cfg
);
    import rfc_pkg::*;

    t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.type_first_valid   <= 8'd1;
            r_cfg.type_end_exclusive <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TYPE_FIRST_VALID:   r_cfg.type_first_valid   <= i_cfg_data[7:0];
                CFG_TYPE_END_EXCLUSIVE: r_cfg.type_end_exclusive <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/rfc_frame_tracker.sv @@
// frame state, header capture, crc and status for each byte transfer
module rfc_frame_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_xfer,
    input  logic [7:0]       i_data_byte,
    input  logic             i_buffer_end,
    input  rfc_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output rfc_pkg::t_result o_res
);
    import rfc_pkg::*;

    localparam logic [POS_W-1:0] HDR_END = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_BYTES - 1);

    logic [POS_W-1:0] r_pos,       n_pos;
    logic [15:0]      r_crc,       n_crc;
    logic [15:0]      r_frame_crc, n_frame_crc;
    logic [15:0]      r_rx_crc,    n_rx_crc;
    logic [63:0]      r_hdr,       n_hdr;
    logic [7:0]       r_kind,      n_kind;
    logic             r_complete,  n_complete;

    logic [POS_W-1:0] region;
    logic [15:0]      crc_upd;
    logic             type_bad;

    assign crc_upd = crc_byte(r_crc, i_data_byte);
    assign region  = HDR_END + POS_W'(r_hdr[15:0]);

    // next frame state for the byte on the input
    always_comb begin
        n_pos       = (r_pos != POS_MAX) ? r_pos + 1'b1 : r_pos;
        n_crc       = r_crc;
        n_frame_crc = r_frame_crc;
        n_rx_crc    = r_rx_crc;
        n_hdr       = r_hdr;
        n_kind      = r_kind;
        n_complete  = r_complete;
        if (r_pos < HDR_END) begin
            n_crc = crc_upd;
            case (r_pos[3:0])
                4'd0:    n_kind        = i_data_byte;
                4'd1:    n_hdr[63:56]  = i_data_byte;
                4'd2:    n_hdr[55:48]  = i_data_byte;
                4'd3:    n_hdr[47:40]  = i_data_byte;
                4'd4:    n_hdr[39:32]  = i_data_byte;
                4'd5:    n_hdr[31:24]  = i_data_byte;
                4'd6:    n_hdr[23:16]  = i_data_byte;
                4'd7:    n_hdr[15:8]   = i_data_byte;
                4'd8:    n_hdr[7:0]    = i_data_byte;
                default: ;
            endcase
        end else if (r_pos < region) begin
            n_crc = crc_upd;
        end else if (r_pos == region) begin
            n_frame_crc = r_crc;
            n_rx_crc    = {i_data_byte, 8'h00};
        end else if (r_pos == region + 1'b1) begin
            n_rx_crc[7:0] = i_data_byte;
            n_complete    = 1'b1;
        end
    end

    // status with precedence: short header, type window, short frame, crc
    assign type_bad = (n_kind < i_cfg.type_first_valid) ||
                      ({1'b0, n_kind} >= i_cfg.type_end_exclusive);

    always_comb begin
        if (r_pos < HDR_LAST) begin
            o_res.status = ST_TOO_SHORT;
        end else if (type_bad) begin
            o_res.status = ST_BAD_TYPE;
        end else if (!n_complete) begin
            o_res.status = ST_TOO_SHORT;
        end else if (n_frame_crc != n_rx_crc) begin
            o_res.status = ST_CRC_ERR;
        end else begin
            o_res.status = ST_OK;
        end
        o_res.msg_kind     = n_kind;
        o_res.hops_taken   = n_hdr[63:56];
        o_res.hops_allowed = n_hdr[55:48];
        o_res.origin_node  = n_hdr[47:16];
        o_res.body_length  = n_hdr[15:0];
    end

    assign o_res_valid = i_xfer && i_buffer_end;

    // state update, back to frame start after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_xfer && i_buffer_end)) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_frame_crc <= '0;
            r_rx_crc    <= '0;
            r_hdr       <= '0;
            r_kind      <= '0;
            r_complete  <= 1'b0;
        end else if (i_xfer) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_frame_crc <= n_frame_crc;
            r_rx_crc    <= n_rx_crc;
            r_hdr       <= n_hdr;
            r_kind      <= n_kind;
            r_complete  <= n_complete;
        end
    end

endmodule

@@ hw/rtl/rfc_out_stage.sv @@
// result register toward the output channel
module rfc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  rfc_pkg::t_result i_res,
    output logic             o_can_take,
    rfc_result_if.source     o_out
);
    import rfc_pkg::*;

    logic    r_valid;
    t_result r_res;

    // register is free when empty or drained in this cycle
    assign o_can_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_res_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_can_take && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.status       = r_res.status;
    assign o_out.msg_kind     = r_res.msg_kind;
    assign o_out.hops_taken   = r_res.hops_taken;
    assign o_out.hops_allowed = r_res.hops_allowed;
    assign o_out.origin_node  = r_res.origin_node;
    assign o_out.body_length  = r_res.body_length;

endmodule

@@ hw/rtl/relay_frame_checker_top.sv @@
// relay frame checker top level: byte stream in, one frame result per buffer out
//
//  channel   dir  payload                                         handshake
//  i_in      in   data_byte[8], buffer_end[1]                     valid / ready
//  o_out     out  status[2], msg_kind[8], hops_taken[8],
//                 hops_allowed[8], origin_node[32], body_length[16] valid / ready
//  cfg       in   i_cfg_we, i_cfg_index[1], i_cfg_data[9]         write only
//
//  one byte per cycle; the crc byte update and the header capture sit between the
//  frame state registers, and the result lands in the output register in the cycle
//  after the final byte.
//  synchronous active-low reset clears the frame state, config to its defaults.
//  input stalls only while the output register holds a result not yet taken.
module relay_frame_checker_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rfc_byte_if.sink                       i_in,
    rfc_result_if.source                   o_out
);
    import rfc_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    can_take;
    logic    xfer;

    assign i_in.ready = can_take;
    assign xfer       = i_in.valid && can_take;

    // configuration registers
    rfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // frame tracking per byte transfer
    rfc_frame_tracker u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_xfer       (xfer),
        .i_data_byte  (i_in.data_byte),
        .i_buffer_end (i_in.buffer_end),
        .i_cfg        (cfg),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // result register
    rfc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_take  (can_take),
        .o_out       (o_out)
    );

endmodule
